FILE: src/gga_pkg.sv
package gga_pkg;

    localparam int TimeWidth = 30;
    localparam int LatWidth  = 27;
    localparam int LonWidth  = 30;
    localparam int AccWidth  = 30;

    localparam logic [TimeWidth-1:0] TIME_FALLBACK = 30'd3333333;
    localparam logic [LatWidth-1:0]  LAT_FALLBACK  = 27'd2222220;
    localparam logic [LonWidth-1:0]  LON_FALLBACK  = 30'd1111110;

    localparam logic [7:0] LAT_FALLBACK_CHAR = 8'h5A; // 'Z'
    localparam logic [7:0] LON_FALLBACK_CHAR = 8'h58; // 'X'
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_W     = 8'h57;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] DIGIT_LOW  = 8'd48;
    localparam logic [7:0] DIGIT_HIGH = 8'd57;

    localparam logic [2:0] FIELD_HEADER  = 3'd0;
    localparam logic [2:0] FIELD_TIME    = 3'd1;
    localparam logic [2:0] FIELD_LAT     = 3'd2;
    localparam logic [2:0] FIELD_LAT_HEM = 3'd3;
    localparam logic [2:0] FIELD_LON     = 3'd4;
    localparam logic [2:0] FIELD_LON_HEM = 3'd5;
    localparam logic [2:0] FIELD_DONE    = 3'd6;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_byte;
    } gga_in_t;

    typedef struct packed {
        logic [TimeWidth-1:0] time_thousandths;
        logic                 time_valid;
        logic [LatWidth-1:0]  latitude_ten_thousandths;
        logic                 latitude_valid;
        logic [7:0]           latitude_hemisphere;
        logic [LonWidth-1:0]  longitude_ten_thousandths;
        logic                 longitude_valid;
        logic [7:0]           longitude_hemisphere;
    } gga_out_t;

    typedef struct packed {
        logic [3:0] len;
        logic [3:0] dot;
    } field_shape_t;

    // Expected length and point position of a numeric field; zero length otherwise.
    function automatic field_shape_t field_shape(input logic [2:0] idx);
        field_shape_t s;
        s = '{len: 4'd0, dot: 4'd0};
        case (idx)
            FIELD_TIME: s = '{len: 4'd10, dot: 4'd6};
            FIELD_LAT:  s = '{len: 4'd9,  dot: 4'd4};
            FIELD_LON:  s = '{len: 4'd10, dot: 4'd5};
            default:    s = '{len: 4'd0,  dot: 4'd0};
        endcase
        return s;
    endfunction

endpackage

FILE: src/gga_in_if.sv
interface gga_in_if
    import gga_pkg::*;
();
    logic    valid;
    logic    ready;
    gga_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/gga_out_if.sv
interface gga_out_if
    import gga_pkg::*;
();
    logic     valid;
    logic     ready;
    gga_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/nmea_gga_position_parser.sv
// GGA sentence parser: takes one ASCII byte per word on the sentence channel and,
// on the word flagged last_byte, delivers one position word holding UTC time in
// thousandths, latitude and longitude in ten-thousandths, the two hemisphere letters
// and three valid flags; fields that are malformed or never terminated by a comma
// read back as their fallback values. A byte is held in the input register while
// the field parser works on it, and the position word of the last byte goes into
// the output register as that byte is stepped. Throughput is one byte per clock for
// as long as result words are taken; a position word that waits holds up the input.
module nmea_gga_position_parser
    import gga_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gga_in_if.sink    sentence,
    gga_out_if.source position
);

    logic     in_valid_reg;
    gga_in_t  in_word_reg;
    logic     out_free;
    logic     step;
    logic     done;
    gga_out_t result;

    assign step           = in_valid_reg && out_free;
    assign sentence.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sentence.ready)
            in_valid_reg <= sentence.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sentence.ready && sentence.valid)
            in_word_reg <= sentence.data;
    end

    gga_field_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (in_word_reg),
        .done   (done),
        .result (result)
    );

    gga_result_reg u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (done),
        .result   (result),
        .free     (out_free),
        .position (position)
    );

endmodule

FILE: src/gga_field_parser.sv
module gga_field_parser
    import gga_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  gga_in_t  word,
    output logic     done,
    output gga_out_t result
);

    logic [2:0]           field_index_reg, field_index_next;
    logic [3:0]           count_reg, count_next;
    logic [AccWidth-1:0]  acc_reg, acc_next;
    logic                 shape_ok_reg, shape_ok_next;
    logic [7:0]           first_reg, first_next;
    logic [TimeWidth-1:0] time_reg, time_next;
    logic [LatWidth-1:0]  lat_reg, lat_next;
    logic [LonWidth-1:0]  lon_reg, lon_next;
    logic [7:0]           lat_hem_reg, lat_hem_next;
    logic [7:0]           lon_hem_reg, lon_hem_next;
    logic [2:0]           flags_reg, flags_next;

    field_shape_t        shape;
    logic                is_comma;
    logic                commit_ok;
    logic [AccWidth-1:0] acc_times_ten;
    logic [7:0]          c;

    assign c             = word.char_in;
    assign shape         = field_shape(field_index_reg);
    assign is_comma      = (c == CHAR_COMMA);
    assign commit_ok     = shape_ok_reg && (count_reg == shape.len);
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);

    always_comb
    begin
        field_index_next = field_index_reg;
        count_next       = count_reg;
        acc_next         = acc_reg;
        shape_ok_next    = shape_ok_reg;
        first_next       = first_reg;
        time_next        = time_reg;
        lat_next         = lat_reg;
        lon_next         = lon_reg;
        lat_hem_next     = lat_hem_reg;
        lon_hem_next     = lon_hem_reg;
        flags_next       = flags_reg;

        if (step && field_index_reg != FIELD_DONE)
        begin
            if (is_comma)
            begin
                // The comma closes the current field and opens the next one.
                case (field_index_reg)
                    FIELD_TIME:
                    begin
                        if (commit_ok)
                        begin
                            time_next     = acc_reg;
                            flags_next[0] = 1'b1;
                        end
                    end
                    FIELD_LAT:
                    begin
                        if (commit_ok)
                        begin
                            lat_next      = acc_reg[LatWidth-1:0];
                            flags_next[1] = 1'b1;
                        end
                    end
                    FIELD_LAT_HEM:
                    begin
                        if (count_reg != 4'd0 && (first_reg == CHAR_N || first_reg == CHAR_S))
                            lat_hem_next = first_reg;
                    end
                    FIELD_LON:
                    begin
                        if (commit_ok)
                        begin
                            lon_next      = acc_reg;
                            flags_next[2] = 1'b1;
                        end
                    end
                    FIELD_LON_HEM:
                    begin
                        if (count_reg != 4'd0 && (first_reg == CHAR_E || first_reg == CHAR_W))
                            lon_hem_next = first_reg;
                    end
                    default:
                    begin
                    end
                endcase
                field_index_next = field_index_reg + 3'd1;
                count_next       = 4'd0;
                acc_next         = '0;
                shape_ok_next    = 1'b1;
                first_next       = 8'd0;
            end
            else if (field_index_reg != FIELD_HEADER)
            begin
                if (count_reg == 4'd0)
                    first_next = c;
                if (shape.len != 4'd0 && shape_ok_reg)
                begin
                    if (count_reg >= shape.len)
                        shape_ok_next = 1'b0;
                    else if (count_reg == shape.dot)
                    begin
                        if (c != CHAR_POINT)
                            shape_ok_next = 1'b0;
                    end
                    else if (c inside {[DIGIT_LOW:DIGIT_HIGH]})
                        acc_next = acc_times_ten + AccWidth'(c - DIGIT_LOW);
                    else
                        shape_ok_next = 1'b0;
                end
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + 4'd1;
            end
        end
    end

    assign done = step && word.last_byte;

    always_comb
    begin
        result.time_thousandths          = time_next;
        result.time_valid                = flags_next[0];
        result.latitude_ten_thousandths  = lat_next;
        result.latitude_valid            = flags_next[1];
        result.latitude_hemisphere       = lat_hem_next;
        result.longitude_ten_thousandths = lon_next;
        result.longitude_valid           = flags_next[2];
        result.longitude_hemisphere      = lon_hem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= FIELD_HEADER;
            count_reg       <= 4'd0;
            acc_reg         <= '0;
            shape_ok_reg    <= 1'b1;
            first_reg       <= 8'd0;
            time_reg        <= TIME_FALLBACK;
            lat_reg         <= LAT_FALLBACK;
            lon_reg         <= LON_FALLBACK;
            lat_hem_reg     <= LAT_FALLBACK_CHAR;
            lon_hem_reg     <= LON_FALLBACK_CHAR;
            flags_reg       <= 3'd0;
        end
        else if (done)
        begin
            // The sentence is finished: start over for the next one.
            field_index_reg <= FIELD_HEADER;
            count_reg       <= 4'd0;
            acc_reg         <= '0;
            shape_ok_reg    <= 1'b1;
            first_reg       <= 8'd0;
            time_reg        <= TIME_FALLBACK;
            lat_reg         <= LAT_FALLBACK;
            lon_reg         <= LON_FALLBACK;
            lat_hem_reg     <= LAT_FALLBACK_CHAR;
            lon_hem_reg     <= LON_FALLBACK_CHAR;
            flags_reg       <= 3'd0;
        end
        else
        begin
            field_index_reg <= field_index_next;
            count_reg       <= count_next;
            acc_reg         <= acc_next;
            shape_ok_reg    <= shape_ok_next;
            first_reg       <= first_next;
            time_reg        <= time_next;
            lat_reg         <= lat_next;
            lon_reg         <= lon_next;
            lat_hem_reg     <= lat_hem_next;
            lon_hem_reg     <= lon_hem_next;
            flags_reg       <= flags_next;
        end
    end

endmodule

FILE: src/gga_result_reg.sv
module gga_result_reg
    import gga_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  gga_out_t  result,
    output logic      free,
    gga_out_if.source position
);

    logic     valid_reg;
    gga_out_t data_reg;

    // The register can take a new word when empty or when its word leaves this cycle.
    assign free           = !valid_reg || position.ready;
    assign position.valid = valid_reg;
    assign position.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= result;
    end

endmodule

FILE: bench/gga_position_checker.sv
module gga_position_checker
    import gga_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    gga_in_if    sentence,
    gga_out_if   position,
    output int   outstanding,
    output int   failures
);

    logic [2:0]          field_idx;
    logic [3:0]          char_cnt;
    logic [AccWidth-1:0] acc;
    logic                shape_good;
    logic [7:0]          first_char;
    gga_out_t            held;
    gga_out_t            want_word;
    gga_out_t            expected_positions[$];
    int                  mismatch_count = 0;

    function automatic logic [3:0] numeric_length(input logic [2:0] idx);
        case (idx)
            FIELD_TIME: return 4'd10;
            FIELD_LAT:  return 4'd9;
            FIELD_LON:  return 4'd10;
            default:    return 4'd0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic clear_field_state();
        char_cnt   = '0;
        acc        = '0;
        shape_good = 1'b1;
        first_char = '0;
    endtask

    task automatic restart_sentence();
        field_idx = FIELD_HEADER;
        clear_field_state();
        held = '{time_thousandths:          TIME_FALLBACK,
                 time_valid:                1'b0,
                 latitude_ten_thousandths:  LAT_FALLBACK,
                 latitude_valid:            1'b0,
                 latitude_hemisphere:       LAT_FALLBACK_CHAR,
                 longitude_ten_thousandths: LON_FALLBACK,
                 longitude_valid:           1'b0,
                 longitude_hemisphere:      LON_FALLBACK_CHAR};
    endtask

    task automatic take_field_char(input logic [7:0] c);
        logic [3:0] want_len;
        logic [3:0] point_pos;
        want_len  = numeric_length(field_idx);
        point_pos = (field_idx == FIELD_TIME) ? 4'd6 : (field_idx == FIELD_LAT) ? 4'd4 : 4'd5;
        if (char_cnt == 4'd0)
            first_char = c;
        if (want_len != 4'd0 && shape_good)
        begin
            if (char_cnt >= want_len)
                shape_good = 1'b0;
            else if (char_cnt == point_pos)
            begin
                if (c != CHAR_POINT)
                    shape_good = 1'b0;
            end
            else if (c >= DIGIT_LOW && c <= DIGIT_HIGH)
                acc = AccWidth'(acc * 10 + (c - DIGIT_LOW));
            else
                shape_good = 1'b0;
        end
        if (char_cnt != COUNT_MAX)
            char_cnt++;
    endtask

    task automatic commit_field();
        logic whole;
        whole = shape_good && char_cnt == numeric_length(field_idx);
        case (field_idx)
            FIELD_TIME:
                if (whole)
                begin
                    held.time_thousandths = acc;
                    held.time_valid       = 1'b1;
                end
            FIELD_LAT:
                if (whole)
                begin
                    held.latitude_ten_thousandths = acc[LatWidth-1:0];
                    held.latitude_valid           = 1'b1;
                end
            FIELD_LAT_HEM:
                if (char_cnt != 4'd0 && (first_char == CHAR_N || first_char == CHAR_S))
                    held.latitude_hemisphere = first_char;
            FIELD_LON:
                if (whole)
                begin
                    held.longitude_ten_thousandths = acc;
                    held.longitude_valid           = 1'b1;
                end
            FIELD_LON_HEM:
                if (char_cnt != 4'd0 && (first_char == CHAR_E || first_char == CHAR_W))
                    held.longitude_hemisphere = first_char;
            default: ;
        endcase
    endtask

    task automatic parse_gga_byte(input gga_in_t w);
        if (field_idx == FIELD_HEADER)
        begin
            if (w.char_in == CHAR_COMMA)
            begin
                field_idx = FIELD_TIME;
                clear_field_state();
            end
        end
        else if (field_idx < FIELD_DONE)
        begin
            if (w.char_in == CHAR_COMMA)
            begin
                commit_field();
                field_idx++;
                clear_field_state();
            end
            else
                take_field_char(w.char_in);
        end
        // The last byte is parsed first, so a comma there still commits its field.
        if (w.last_byte)
        begin
            expected_positions.push_back(held);
            restart_sentence();
        end
    endtask

    task automatic compare_position(input gga_out_t want, input gga_out_t got);
        if (got.time_thousandths !== want.time_thousandths)
            report_mismatch("time_thousandths", 32'(want.time_thousandths),
                            32'(got.time_thousandths));
        if (got.time_valid !== want.time_valid)
            report_mismatch("time_valid", 32'(want.time_valid), 32'(got.time_valid));
        if (got.latitude_ten_thousandths !== want.latitude_ten_thousandths)
            report_mismatch("latitude_ten_thousandths", 32'(want.latitude_ten_thousandths),
                            32'(got.latitude_ten_thousandths));
        if (got.latitude_valid !== want.latitude_valid)
            report_mismatch("latitude_valid", 32'(want.latitude_valid),
                            32'(got.latitude_valid));
        if (got.latitude_hemisphere !== want.latitude_hemisphere)
            report_mismatch("latitude_hemisphere", 32'(want.latitude_hemisphere),
                            32'(got.latitude_hemisphere));
        if (got.longitude_ten_thousandths !== want.longitude_ten_thousandths)
            report_mismatch("longitude_ten_thousandths", 32'(want.longitude_ten_thousandths),
                            32'(got.longitude_ten_thousandths));
        if (got.longitude_valid !== want.longitude_valid)
            report_mismatch("longitude_valid", 32'(want.longitude_valid),
                            32'(got.longitude_valid));
        if (got.longitude_hemisphere !== want.longitude_hemisphere)
            report_mismatch("longitude_hemisphere", 32'(want.longitude_hemisphere),
                            32'(got.longitude_hemisphere));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_sentence();
            expected_positions.delete();
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            if (position.valid && position.ready)
            begin
                if (expected_positions.size() == 0)
                    report_mismatch("position word with none expected", 32'd0, 32'd1);
                else
                begin
                    want_word = expected_positions.pop_front();
                    compare_position(want_word, position.data);
                end
            end
            if (sentence.valid && sentence.ready)
                parse_gga_byte(sentence.data);
            outstanding <= expected_positions.size();
            failures    <= mismatch_count;
        end
    end

endmodule

FILE: bench/testbench.sv
module testbench;
    import gga_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    int         idle_pct;
    int         stall_pct;
    int         outstanding;
    int         failures;
    int         bytes_sent;
    int         sentences_sent;
    int         target_bytes;
    int         target_sentences;
    logic [7:0] line[$];
    logic [7:0] fld[$];

    gga_in_if  sentence ();
    gga_out_if position ();

    nmea_gga_position_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sentence (sentence),
        .position (position)
    );

    gga_position_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sentence    (sentence),
        .position    (position),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        position.ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_word(input logic [7:0] ch, input logic is_last);
        gga_in_t w;
        w.char_in   = ch;
        w.last_byte = is_last;
        while ($urandom_range(99) < idle_pct)
        begin
            sentence.valid <= 1'b0;
            @(posedge clk);
        end
        sentence.valid <= 1'b1;
        sentence.data  <= w;
        @(posedge clk);
        while (!sentence.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line.size(); i++)
            send_word(line[i], i == line.size() - 1);
        sentences_sent++;
        line.delete();
    endtask

    // Holds the sentence channel idle until every position word has come back.
    task automatic wait_for_drain();
        sentence.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line.push_back(s.getc(i));
    endtask

    task automatic make_number(input int whole, input int frac);
        int mode;
        mode = $urandom_range(9);
        fld.delete();
        for (int i = 0; i < whole + frac + 1; i++)
        begin
            if (i == whole)
                fld.push_back(CHAR_POINT);
            else if (mode == 0)
                fld.push_back(DIGIT_HIGH);
            else if (mode == 1)
                fld.push_back(DIGIT_LOW);
            else
                fld.push_back(8'(DIGIT_LOW + $urandom_range(9)));
        end
    endtask

    task automatic damage_field();
        int pick;
        int pos;
        pick = $urandom_range(4);
        pos  = (fld.size() == 0) ? 0 : $urandom_range(fld.size() - 1);
        case (pick)
            0: if (fld.size() != 0) fld.delete(pos);
            1: fld.insert(pos, 8'(DIGIT_LOW + $urandom_range(9)));
            2: if (fld.size() != 0) fld[pos] = 8'($urandom_range(255));
            3: if (fld.size() != 0) fld[pos] = (fld[pos] == CHAR_POINT) ? DIGIT_LOW : CHAR_POINT;
            // Up to twelve extra digits, which can push the character count into saturation.
            default: repeat ($urandom_range(12, 3)) fld.push_back(8'(DIGIT_LOW + $urandom_range(9)));
        endcase
    endtask

    task automatic make_hemisphere(input logic [7:0] a, input logic [7:0] b);
        int r;
        r = $urandom_range(9);
        fld.delete();
        if (r < 6)
            fld.push_back(r[0] ? a : b);
        else if (r == 6)
        begin
            fld.push_back($urandom_range(1) ? a : b);
            repeat ($urandom_range(3, 1)) fld.push_back(8'($urandom_range(126, 33)));
        end
        else if (r != 7)
            fld.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_field();
        foreach (fld[i])
            line.push_back(fld[i]);
        line.push_back(CHAR_COMMA);
    endtask

    task automatic build_sentence();
        int kind;
        int cut;
        kind = $urandom_range(99);
        line.delete();
        if (kind < 12)
        begin
            repeat ($urandom_range(20, 1))
                line.push_back(($urandom_range(3) == 0) ? CHAR_COMMA : 8'($urandom_range(255)));
        end
        else
        begin
            case ($urandom_range(2))
                0: put_text("$GPGGA");
                1: ;
                default: repeat ($urandom_range(8, 1)) line.push_back(8'($urandom_range(126, 45)));
            endcase
            line.push_back(CHAR_COMMA);
            make_number(6, 3);
            if ($urandom_range(99) < 12)
                damage_field();
            put_field();
            make_number(4, 4);
            if ($urandom_range(99) < 12)
                damage_field();
            put_field();
            make_hemisphere(CHAR_N, CHAR_S);
            put_field();
            make_number(5, 4);
            if ($urandom_range(99) < 12)
                damage_field();
            put_field();
            make_hemisphere(CHAR_E, CHAR_W);
            put_field();
            if ($urandom_range(1))
                repeat ($urandom_range(20, 1))
                    line.push_back(($urandom_range(4) == 0) ? CHAR_COMMA
                                                            : 8'($urandom_range(126, 32)));
            // Cutting the sentence short can leave a field without its comma.
            if ($urandom_range(99) < 15)
            begin
                cut = $urandom_range(line.size(), 1);
                while (line.size() > cut)
                    void'(line.pop_back());
            end
        end
    endtask

    initial
    begin
        sentence.valid = 1'b0;
        sentence.data  = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        bytes_sent     = 0;
        sentences_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        line.push_back(8'h00);
        send_line();
        line.push_back(8'hFF);
        send_line();
        put_text(",,,S,,E,");
        send_line();
        put_text(",,,Nq,,Wz");
        send_line();
        put_text(",12,,,");
        send_line();
        wait_for_drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 79; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            target_bytes     = bytes_sent + 440;
            target_sentences = sentences_sent + 8;
            while (bytes_sent < target_bytes || sentences_sent < target_sentences)
            begin
                build_sentence();
                send_line();
                if ($urandom_range(99) < 3)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        repeat (10) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
